@@ rtl/core/ccrd_pkg.sv @@
// shared types, constants and register codes for the controller report decoder
`timescale 1ns / 1ps
`default_nettype none

package ccrd_pkg;

    // axis lanes: left x, left y, right x, right y
    localparam int NUM_LANES = 4;
    localparam int LANE_LX   = 0;
    localparam int LANE_LY   = 1;
    localparam int LANE_RX   = 2;
    localparam int LANE_RY   = 3;

    // widths of the axis datapath
    localparam int AXIS_W      = 6;
    localparam int RAXIS_W     = 5;
    localparam int QUO_W       = 8;
    localparam int NUM_W       = AXIS_W + QUO_W;
    localparam int LANE_STAGES = QUO_W + 1;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_LEFT_X_LOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_X_HIGH  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEFT_Y_LOW   = 3'd2;
    localparam logic [IDX_W-1:0] REG_LEFT_Y_HIGH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RIGHT_X_LOW  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_X_HIGH = 3'd5;
    localparam logic [IDX_W-1:0] REG_RIGHT_Y_LOW  = 3'd6;
    localparam logic [IDX_W-1:0] REG_RIGHT_Y_HIGH = 3'd7;

    // how a lane result is to be read
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ZERO   = 2'd1,
        MODE_FULL   = 2'd2
    } axis_mode_t;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        axis_mode_t       mode;
    } lane_res_t;

    typedef struct packed {
        logic [AXIS_W-1:0]  left_x_low;
        logic [AXIS_W-1:0]  left_x_high;
        logic [AXIS_W-1:0]  left_y_low;
        logic [AXIS_W-1:0]  left_y_high;
        logic [RAXIS_W-1:0] right_x_low;
        logic [RAXIS_W-1:0] right_x_high;
        logic [RAXIS_W-1:0] right_y_low;
        logic [RAXIS_W-1:0] right_y_high;
    } cal_t;

    localparam cal_t CAL_RESET = '{
        left_x_low:   6'd0,
        left_x_high:  6'd63,
        left_y_low:   6'd0,
        left_y_high:  6'd63,
        right_x_low:  5'd0,
        right_x_high: 5'd31,
        right_y_low:  5'd0,
        right_y_high: 5'd31
    };

    typedef struct packed {
        logic [15:0]      pad_buttons;
        logic [QUO_W-1:0] stick_left_x;
        logic [QUO_W-1:0] stick_left_y;
        logic [QUO_W-1:0] stick_right_x;
        logic [QUO_W-1:0] stick_right_y;
        logic             combo_pressed;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ccrd_ifs.sv @@
// report and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface ccrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte_zero;
    logic [7:0] report_byte_one;
    logic [7:0] report_byte_two;
    logic [7:0] report_byte_three;
    logic [7:0] report_byte_four;
    logic [7:0] report_byte_five;

    modport source (
        output valid, report_byte_zero, report_byte_one, report_byte_two,
               report_byte_three, report_byte_four, report_byte_five,
        input  ready
    );
    modport sink (
        input  valid, report_byte_zero, report_byte_one, report_byte_two,
               report_byte_three, report_byte_four, report_byte_five,
        output ready
    );
endinterface

interface ccrd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pad_buttons;
    logic [7:0]  stick_left_x;
    logic [7:0]  stick_left_y;
    logic [7:0]  stick_right_x;
    logic [7:0]  stick_right_y;
    logic        combo_pressed;

    modport source (
        output valid, pad_buttons, stick_left_x, stick_left_y, stick_right_x,
               stick_right_y, combo_pressed,
        input  ready
    );
    modport sink (
        input  valid, pad_buttons, stick_left_x, stick_left_y, stick_right_x,
               stick_right_y, combo_pressed,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/classic_controller_report_decode.sv @@
// controller report decoder top level
//
//   channel   dir   handshake          carries
//   rpt       in    valid / ready      six report bytes
//   pad       out   valid / ready      button word, four stick axes, combo flag
//   apb       in    psel / penable     calibration registers, 4-byte stride
//
// one report a cycle while the input is not stalled; the front stage
// loads at the transfer edge, then come 8 divider stages, one per quotient bit,
// and the merge register
// each stage holds its item until the next stage frees, so a stalled result
// does not stop transfers until every stage is full
// reset clears the stage valid bits and loads the default calibration
`timescale 1ns / 1ps
`default_nettype none

module classic_controller_report_decode
    import ccrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ccrd_in_if.sink                rpt,
    ccrd_out_if.source             pad,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cal_t                   cal;
    logic [LANE_STAGES-1:0] stg_vld_reg;
    logic [LANE_STAGES-1:0] stg_vld_next;
    logic [LANE_STAGES-1:0] stg_rdy;
    logic [15:0]            btn_reg [LANE_STAGES];
    logic                   out_rdy;
    logic                   out_vld;
    result_t                out_data;
    lane_res_t              lane_res [NUM_LANES];
    logic [AXIS_W-1:0]      lane_v   [NUM_LANES];
    logic [AXIS_W-1:0]      lane_lo  [NUM_LANES];
    logic [AXIS_W-1:0]      lane_hi  [NUM_LANES];

    ccrd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // ready ripples back from the merge register through every stage
    assign out_rdy = !out_vld || pad.ready;

    always_comb
    begin
        stg_rdy[LANE_STAGES-1] = !stg_vld_reg[LANE_STAGES-1] || out_rdy;
        for (int k = LANE_STAGES - 2; k >= 0; k--)
        begin
            stg_rdy[k] = !stg_vld_reg[k] || stg_rdy[k+1];
        end
    end

    assign rpt.ready = stg_rdy[0];

    // stage valid bits
    always_comb
    begin
        stg_vld_next[0] = stg_rdy[0] ? rpt.valid : stg_vld_reg[0];
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            stg_vld_next[k] = stg_rdy[k] ? stg_vld_reg[k-1] : stg_vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= '0;
        end
        else
        begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    // raw button bytes travel beside the divider
    always_ff @(posedge clk)
    begin
        if (stg_rdy[0])
        begin
            btn_reg[0] <= {rpt.report_byte_four, rpt.report_byte_five};
        end
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (stg_rdy[k])
            begin
                btn_reg[k] <= btn_reg[k-1];
            end
        end
    end

    // unpack stick axes from the report
    always_comb
    begin
        lane_v[LANE_LX]  = rpt.report_byte_zero[AXIS_W-1:0];
        lane_v[LANE_LY]  = rpt.report_byte_one[AXIS_W-1:0];
        lane_v[LANE_RX]  = AXIS_W'({rpt.report_byte_zero[7:6], rpt.report_byte_one[7:6],
                                    rpt.report_byte_two[7]});
        lane_v[LANE_RY]  = AXIS_W'(rpt.report_byte_two[RAXIS_W-1:0]);
        lane_lo[LANE_LX] = cal.left_x_low;
        lane_hi[LANE_LX] = cal.left_x_high;
        lane_lo[LANE_LY] = cal.left_y_low;
        lane_hi[LANE_LY] = cal.left_y_high;
        lane_lo[LANE_RX] = AXIS_W'(cal.right_x_low);
        lane_hi[LANE_RX] = AXIS_W'(cal.right_x_high);
        lane_lo[LANE_RY] = AXIS_W'(cal.right_y_low);
        lane_hi[LANE_RY] = AXIS_W'(cal.right_y_high);
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        ccrd_lane u_lane (
            .clk (clk),
            .en  (stg_rdy),
            .v   (lane_v[i]),
            .lo  (lane_lo[i]),
            .hi  (lane_hi[i]),
            .res (lane_res[i])
        );
    end

    ccrd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_rdy),
        .vld_in   (stg_vld_reg[LANE_STAGES-1]),
        .res      (lane_res),
        .btn_raw  (btn_reg[LANE_STAGES-1]),
        .out_vld  (out_vld),
        .out_data (out_data)
    );

    assign pad.valid         = out_vld;
    assign pad.pad_buttons   = out_data.pad_buttons;
    assign pad.stick_left_x  = out_data.stick_left_x;
    assign pad.stick_left_y  = out_data.stick_left_y;
    assign pad.stick_right_x = out_data.stick_right_x;
    assign pad.stick_right_y = out_data.stick_right_y;
    assign pad.combo_pressed = out_data.combo_pressed;

`ifndef SYNTH
    // a report transfer always lands in the front stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rpt.valid && rpt.ready |=> stg_vld_reg[0])
        else $error("accepted report not in front stage");

    // an empty front stage never refuses a report
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_vld_reg[0] |-> rpt.ready)
        else $error("front stage empty but not ready");

    // back-pressure at the input only when the result side is stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !rpt.ready |-> pad.valid && !pad.ready)
        else $error("input stalled without output stall");

    // a new result comes only from a valid last divider stage
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pad.valid) |-> $past(stg_vld_reg[LANE_STAGES-1]))
        else $error("result valid without item in last stage");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ccrd_cfg.sv @@
// calibration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module ccrd_cfg
    import ccrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cal_t                   cal
);

    cal_t             cal_reg;
    cal_t             cal_next;
    logic [IDX_W-1:0] idx;
    logic             wr;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    // register write decode
    always_comb
    begin
        cal_next = cal_reg;
        if (wr)
        begin
            case (idx)
                REG_LEFT_X_LOW:   cal_next.left_x_low   = pwdata[AXIS_W-1:0];
                REG_LEFT_X_HIGH:  cal_next.left_x_high  = pwdata[AXIS_W-1:0];
                REG_LEFT_Y_LOW:   cal_next.left_y_low   = pwdata[AXIS_W-1:0];
                REG_LEFT_Y_HIGH:  cal_next.left_y_high  = pwdata[AXIS_W-1:0];
                REG_RIGHT_X_LOW:  cal_next.right_x_low  = pwdata[RAXIS_W-1:0];
                REG_RIGHT_X_HIGH: cal_next.right_x_high = pwdata[RAXIS_W-1:0];
                REG_RIGHT_Y_LOW:  cal_next.right_y_low  = pwdata[RAXIS_W-1:0];
                REG_RIGHT_Y_HIGH: cal_next.right_y_high = pwdata[RAXIS_W-1:0];
                default:          cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= CAL_RESET;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_LEFT_X_LOW:   prdata = DATA_W'(cal_reg.left_x_low);
            REG_LEFT_X_HIGH:  prdata = DATA_W'(cal_reg.left_x_high);
            REG_LEFT_Y_LOW:   prdata = DATA_W'(cal_reg.left_y_low);
            REG_LEFT_Y_HIGH:  prdata = DATA_W'(cal_reg.left_y_high);
            REG_RIGHT_X_LOW:  prdata = DATA_W'(cal_reg.right_x_low);
            REG_RIGHT_X_HIGH: prdata = DATA_W'(cal_reg.right_x_high);
            REG_RIGHT_Y_LOW:  prdata = DATA_W'(cal_reg.right_y_low);
            REG_RIGHT_Y_HIGH: prdata = DATA_W'(cal_reg.right_y_high);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/ccrd_lane.sv @@
// one axis lane: clamp, scale by 255 and a one-bit-per-stage divider
`timescale 1ns / 1ps
`default_nettype none

module ccrd_lane
    import ccrd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [LANE_STAGES-1:0] en,
    input  wire logic [AXIS_W-1:0]      v,
    input  wire logic [AXIS_W-1:0]      lo,
    input  wire logic [AXIS_W-1:0]      hi,
    output lane_res_t                   res
);

    logic [NUM_W-1:0]  rem_reg  [LANE_STAGES];
    logic [QUO_W-1:0]  quo_reg  [LANE_STAGES];
    logic [AXIS_W-1:0] den_reg  [LANE_STAGES];
    axis_mode_t        mode_reg [LANE_STAGES];

    logic [AXIS_W-1:0] vc;
    logic [AXIS_W-1:0] diff;
    logic [NUM_W-1:0]  num;
    axis_mode_t        mode;

    // clamp into calibrated range and form (v - lo) * 255
    always_comb
    begin
        if (v < lo)
        begin
            vc = lo;
        end
        else if (v > hi)
        begin
            vc = hi;
        end
        else
        begin
            vc = v;
        end
        diff = vc - lo;
        num  = {diff, {QUO_W{1'b0}}} - NUM_W'(diff);
        if (lo == hi)
        begin
            mode = MODE_ZERO;
        end
        else if (lo > hi)
        begin
            // reversed range saturates to one end or the other
            mode = (v < lo) ? MODE_ZERO : MODE_FULL;
        end
        else
        begin
            mode = MODE_NORMAL;
        end
    end

    // front stage
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= num;
            quo_reg[0]  <= '0;
            den_reg[0]  <= hi - lo;
            mode_reg[0] <= mode;
        end
    end

    // restoring divider, most significant quotient bit first
    for (genvar k = 1; k < LANE_STAGES; k++)
    begin : g_div
        localparam int BIT = QUO_W - k;
        logic [NUM_W-1:0] trial;
        logic             ge;

        assign trial = NUM_W'(den_reg[k-1]) << BIT;
        assign ge    = rem_reg[k-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= ge ? rem_reg[k-1] - trial : rem_reg[k-1];
                quo_reg[k]  <= quo_reg[k-1] | (QUO_W'(ge) << BIT);
                den_reg[k]  <= den_reg[k-1];
                mode_reg[k] <= mode_reg[k-1];
            end
        end
    end

    assign res.quo  = quo_reg[LANE_STAGES-1];
    assign res.mode = mode_reg[LANE_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/ccrd_merge.sv @@
// merge stage: button word, combo flag, axis saturation and y inversion
`timescale 1ns / 1ps
`default_nettype none

module ccrd_merge
    import ccrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic        vld_in,
    input  wire lane_res_t   res [NUM_LANES],
    input  wire logic [15:0] btn_raw,
    output logic             out_vld,
    output result_t          out_data
);

    logic             out_vld_reg;
    result_t          out_data_reg;
    result_t          data_next;
    logic [7:0]       b4;
    logic [7:0]       b5;
    logic [QUO_W-1:0] scaled [NUM_LANES];

    // pick the lane value by its mode
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            case (res[i].mode)
                MODE_NORMAL: scaled[i] = res[i].quo;
                MODE_ZERO:   scaled[i] = '0;
                MODE_FULL:   scaled[i] = '1;
                default:     scaled[i] = '0;
            endcase
        end
    end

    // buttons are active low in the report
    assign b4 = ~btn_raw[15:8];
    assign b5 = ~btn_raw[7:0];

    always_comb
    begin
        data_next.pad_buttons = {b4[3], 1'b0, b5[2], b4[1], b5[7], b4[5], b4[2], b4[4],
                                 b5[6], b5[4], b5[3], b5[5], b4[6], b5[0], b4[7], b5[1]};
        data_next.combo_pressed = b4[4] & b4[2];
        data_next.stick_left_x  = scaled[LANE_LX];
        data_next.stick_left_y  = ~scaled[LANE_LY];
        data_next.stick_right_x = scaled[LANE_RX];
        data_next.stick_right_y = ~scaled[LANE_RY];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load)
        begin
            out_vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= data_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_data_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_classic_controller_report_decode.sv @@
// self-checking testbench for the controller report decoder
`timescale 1ns / 1ps

module tb_classic_controller_report_decode;
    import ccrd_pkg::*;

    // one six-byte report as it goes onto the report channel
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } rpt_bytes_t;

    localparam int NUM_PHASES    = 12;
    localparam int PHASE_REPORTS = 130;
    localparam int TAIL_CYCLES   = 30;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ccrd_in_if  rpt_if ();
    ccrd_out_if pad_if ();

    classic_controller_report_decode u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rpt     (rpt_if),
        .pad     (pad_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // reports waiting to be driven, decodes waiting to come out
    rpt_bytes_t report_q[$];
    result_t    pad_results_q[$];

    // calibration as the block should hold it
    cal_t cal_shadow;

    bit rpt_xfer;
    int src_gap;
    int src_calm;
    int sink_stall;
    int sink_calm;
    int fail_count;
    int accepted_count;
    int checked_count;
    int phase_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly none or short, sometimes long, with calm stretches
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // clamp to the calibrated range and scale to 0..255, truncated
    function automatic logic [7:0] scale_axis_value(int raw, int lo, int hi);
        int v;
        int q;
        v = raw;
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        if (lo == hi)
            return 8'd0;
        q = ((v - lo) * 255) / (hi - lo);
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    // expected decode of one report under a given calibration
    function automatic result_t decode_report(rpt_bytes_t r, cal_t c);
        logic [7:0] held4;
        logic [7:0] held5;
        logic [4:0] rx_raw;
        result_t    d;
        held4  = ~r.b4;
        held5  = ~r.b5;
        rx_raw = {r.b0[7:6], r.b1[7:6], r.b2[7]};

        // button word, third-stick button stays clear
        d.pad_buttons     = '0;
        d.pad_buttons[0]  = held5[1];
        d.pad_buttons[1]  = held4[7];
        d.pad_buttons[2]  = held5[0];
        d.pad_buttons[3]  = held4[6];
        d.pad_buttons[4]  = held5[5];
        d.pad_buttons[5]  = held5[3];
        d.pad_buttons[6]  = held5[4];
        d.pad_buttons[7]  = held5[6];
        d.pad_buttons[8]  = held4[4];
        d.pad_buttons[9]  = held4[2];
        d.pad_buttons[10] = held4[5];
        d.pad_buttons[11] = held5[7];
        d.pad_buttons[12] = held4[1];
        d.pad_buttons[13] = held5[2];
        d.pad_buttons[15] = held4[3];

        // sticks, y axes inverted
        d.stick_left_x  = scale_axis_value(int'(r.b0[5:0]), int'(c.left_x_low),
                                           int'(c.left_x_high));
        d.stick_left_y  = 8'd255 - scale_axis_value(int'(r.b1[5:0]), int'(c.left_y_low),
                                                    int'(c.left_y_high));
        d.stick_right_x = scale_axis_value(int'(rx_raw), int'(c.right_x_low),
                                           int'(c.right_x_high));
        d.stick_right_y = 8'd255 - scale_axis_value(int'(r.b2[4:0]), int'(c.right_y_low),
                                                    int'(c.right_y_high));
        d.combo_pressed = held4[4] & held4[2];
        return d;
    endfunction

    // raw axis value, biased toward the calibration edges
    function automatic int pick_raw(int lo, int hi, int maxv);
        case ($urandom_range(0, 9))
            5: return lo;
            6: return hi;
            7: return (lo - 1) & maxv;
            8: return (hi + 1) & maxv;
            9: return ($urandom_range(0, 1) != 0) ? maxv : 0;
            default: return $urandom_range(0, maxv);
        endcase
    endfunction

    // random report shaped around the current calibration
    function automatic rpt_bytes_t make_report(cal_t c);
        rpt_bytes_t r;
        logic [5:0] lx;
        logic [5:0] ly;
        logic [4:0] rx;
        logic [4:0] ry;
        lx   = 6'(pick_raw(int'(c.left_x_low), int'(c.left_x_high), 63));
        ly   = 6'(pick_raw(int'(c.left_y_low), int'(c.left_y_high), 63));
        rx   = 5'(pick_raw(int'(c.right_x_low), int'(c.right_x_high), 31));
        ry   = 5'(pick_raw(int'(c.right_y_low), int'(c.right_y_high), 31));
        r.b0 = {rx[4:3], lx};
        r.b1 = {rx[2:1], ly};
        r.b2 = {rx[0], 2'($urandom), ry};
        r.b3 = 8'($urandom);
        r.b4 = 8'($urandom);
        r.b5 = 8'($urandom);
        // hold select and start now and then
        if ($urandom_range(0, 4) == 0)
            r.b4 = r.b4 & 8'b1110_1011;
        return r;
    endfunction

    // low and high bounds: normal, equal, reversed or full span
    function automatic void pick_bounds(int maxv, output int lo, output int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            lo = $urandom_range(0, maxv - 1);
            hi = $urandom_range(lo + 1, maxv);
        end
        else if (r < 75)
        begin
            lo = $urandom_range(0, maxv);
            hi = lo;
        end
        else if (r < 90)
        begin
            hi = $urandom_range(0, maxv - 1);
            lo = $urandom_range(hi + 1, maxv);
        end
        else
        begin
            lo = 0;
            hi = maxv;
        end
    endfunction

    function automatic cal_t random_calibration();
        cal_t c;
        int   lo;
        int   hi;
        pick_bounds(63, lo, hi);
        c.left_x_low  = 6'(lo);
        c.left_x_high = 6'(hi);
        pick_bounds(63, lo, hi);
        c.left_y_low  = 6'(lo);
        c.left_y_high = 6'(hi);
        pick_bounds(31, lo, hi);
        c.right_x_low  = 5'(lo);
        c.right_x_high = 5'(hi);
        pick_bounds(31, lo, hi);
        c.right_y_low  = 5'(lo);
        c.right_y_high = 5'(hi);
        return c;
    endfunction

    // one apb write, junk above the register width
    task automatic cal_write(input logic [IDX_W-1:0] idx, input int value);
        logic [DATA_W-1:0] data;
        data = $urandom();
        if (idx < REG_RIGHT_X_LOW)
            data[5:0] = value[5:0];
        else
            data[4:0] = value[4:0];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_LEFT_X_LOW:   cal_shadow.left_x_low   = data[5:0];
            REG_LEFT_X_HIGH:  cal_shadow.left_x_high  = data[5:0];
            REG_LEFT_Y_LOW:   cal_shadow.left_y_low   = data[5:0];
            REG_LEFT_Y_HIGH:  cal_shadow.left_y_high  = data[5:0];
            REG_RIGHT_X_LOW:  cal_shadow.right_x_low  = data[4:0];
            REG_RIGHT_X_HIGH: cal_shadow.right_x_high = data[4:0];
            REG_RIGHT_Y_LOW:  cal_shadow.right_y_low  = data[4:0];
            REG_RIGHT_Y_HIGH: cal_shadow.right_y_high = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_calibration(input cal_t c);
        cal_write(REG_LEFT_X_LOW,   int'(c.left_x_low));
        cal_write(REG_LEFT_X_HIGH,  int'(c.left_x_high));
        cal_write(REG_LEFT_Y_LOW,   int'(c.left_y_low));
        cal_write(REG_LEFT_Y_HIGH,  int'(c.left_y_high));
        cal_write(REG_RIGHT_X_LOW,  int'(c.right_x_low));
        cal_write(REG_RIGHT_X_HIGH, int'(c.right_x_high));
        cal_write(REG_RIGHT_Y_LOW,  int'(c.right_y_low));
        cal_write(REG_RIGHT_Y_HIGH, int'(c.right_y_high));
    endtask

    // wait until every report is in and every decode is out
    task automatic wait_drained();
        while (report_q.size() != 0 || rpt_if.valid || pad_results_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    // report channel driver
    always @(negedge clk)
    begin : report_driver
        rpt_bytes_t next_rpt;
        if (rst_n && !(rpt_if.valid && !rpt_xfer))
        begin
            if (rpt_xfer)
                src_gap = draw_gap(src_calm);
            if (src_gap == 0 && report_q.size() != 0)
            begin
                next_rpt = report_q.pop_front();
                rpt_if.valid <= 1'b1;
            end
            else
            begin
                if (src_gap > 0)
                    src_gap--;
                next_rpt = {$urandom(), 16'($urandom())};
                rpt_if.valid <= 1'b0;
            end
            rpt_if.report_byte_zero  <= next_rpt.b0;
            rpt_if.report_byte_one   <= next_rpt.b1;
            rpt_if.report_byte_two   <= next_rpt.b2;
            rpt_if.report_byte_three <= next_rpt.b3;
            rpt_if.report_byte_four  <= next_rpt.b4;
            rpt_if.report_byte_five  <= next_rpt.b5;
        end
    end

    // result channel back-pressure
    always @(negedge clk)
    begin : pad_stall
        if (rst_n)
        begin
            if (sink_stall == 0)
                sink_stall = draw_gap(sink_calm);
            if (sink_stall > 0)
            begin
                sink_stall--;
                pad_if.ready <= 1'b0;
            end
            else
                pad_if.ready <= 1'b1;
        end
    end

    // predict on every report transfer
    always @(posedge clk)
    begin : report_monitor
        rpt_bytes_t taken;
        rpt_xfer = rst_n && rpt_if.valid && rpt_if.ready;
        if (rpt_xfer)
        begin
            taken = {rpt_if.report_byte_zero, rpt_if.report_byte_one,
                     rpt_if.report_byte_two, rpt_if.report_byte_three,
                     rpt_if.report_byte_four, rpt_if.report_byte_five};
            pad_results_q.push_back(decode_report(taken, cal_shadow));
            accepted_count++;
        end
    end

    // compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : pad_monitor
        result_t seen;
        result_t want;
        if (rst_n && pad_if.valid && pad_if.ready)
        begin
            seen = {pad_if.pad_buttons, pad_if.stick_left_x, pad_if.stick_left_y,
                    pad_if.stick_right_x, pad_if.stick_right_y, pad_if.combo_pressed};
            if (pad_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
                fail_count++;
            end
            else
            begin
                want = pad_results_q.pop_front();
                check_field("pad_buttons",   want.pad_buttons,   seen.pad_buttons);
                check_field("stick_left_x",  16'(want.stick_left_x),
                            16'(seen.stick_left_x));
                check_field("stick_left_y",  16'(want.stick_left_y),
                            16'(seen.stick_left_y));
                check_field("stick_right_x", 16'(want.stick_right_x),
                            16'(seen.stick_right_x));
                check_field("stick_right_y", 16'(want.stick_right_y),
                            16'(seen.stick_right_y));
                check_field("combo_pressed", 16'(want.combo_pressed),
                            16'(seen.combo_pressed));
                checked_count++;
            end
        end
    end

    // stimulus: directed reports, then calibration phases of random reports
    initial
    begin : stimulus
        cal_t c;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cal_shadow = CAL_RESET;
        rpt_if.valid             = 1'b0;
        rpt_if.report_byte_zero  = '0;
        rpt_if.report_byte_one   = '0;
        rpt_if.report_byte_two   = '0;
        rpt_if.report_byte_three = '0;
        rpt_if.report_byte_four  = '0;
        rpt_if.report_byte_five  = '0;
        pad_if.ready             = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: c = CAL_RESET;
                1: c = '{6'd0, 6'd63, 6'd0, 6'd63, 5'd0, 5'd31, 5'd0, 5'd31};
                // low equal to high on every axis
                2: c = '{6'd20, 6'd20, 6'd63, 6'd63, 5'd31, 5'd31, 5'd0, 5'd0};
                // low above high
                3: c = '{6'd50, 6'd10, 6'd63, 6'd0, 5'd31, 5'd0, 5'd20, 5'd5};
                4: c = '{6'd1, 6'd62, 6'd30, 6'd33, 5'd1, 5'd30, 5'd15, 5'd16};
                5: c = '{6'd0, 6'd0, 6'd63, 6'd0, 5'd0, 5'd0, 5'd31, 5'd0};
                default: c = random_calibration();
            endcase
            if (p != 0)
                set_calibration(c);

            if (p == 0)
            begin
                // all pressed, all released
                report_q.push_back('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
                report_q.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
                // each button bit alone, unused bit 0 of byte four included
                for (int i = 0; i < 8; i++)
                begin
                    report_q.push_back('{8'h15, 8'h2A, 8'h0C, 8'($urandom()),
                                         8'hFF ^ (8'h01 << i), 8'hFF});
                    report_q.push_back('{8'h15, 8'h2A, 8'h0C, 8'($urandom()),
                                         8'hFF, 8'hFF ^ (8'h01 << i)});
                end
                // select and start together
                report_q.push_back('{8'h20, 8'h20, 8'h10, 8'h00, 8'hEB, 8'hFF});
                // stick extremes
                report_q.push_back('{8'hC0, 8'hC0, 8'h80, 8'h5A, 8'hFF, 8'hFF});
                report_q.push_back('{8'h3F, 8'h3F, 8'h1F, 8'hA5, 8'hFF, 8'hFF});
            end
            for (int n = 0; n < PHASE_REPORTS; n++)
                report_q.push_back(make_report(cal_shadow));
            wait_drained();
            phase_count++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d reports decoded and %0d results checked across %0d calibration phases",
                 accepted_count, checked_count, phase_count);
        $display("phases covered reset, full, equal, reversed, narrow and random calibration");
        if (fail_count == 0)
            $display("classic_controller_report_decode regression: pass");
        else
            $display("classic_controller_report_decode regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pad_results_q.size());
        $display("classic_controller_report_decode regression: fail");
        $finish;
    end

endmodule

@@ classic_controller_report_decode.f @@
rtl/core/ccrd_pkg.sv
rtl/core/ccrd_ifs.sv
rtl/core/ccrd_cfg.sv
rtl/core/ccrd_lane.sv
rtl/core/ccrd_merge.sv
rtl/core/classic_controller_report_decode.sv
tb/sv/tb_classic_controller_report_decode.sv
